// File: hw/rtl/trl_pkg.sv
// Shared constants, types and helpers for the tensor roll address generator.
`default_nettype none

package trl_pkg;

   // Tensor shape limits
   localparam int MAX_DIMS    = 4;
   localparam int DIM_BITS    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int EXTENT_BITS = 12;
   localparam int EXT_WIDTH   = 13;
   localparam int SHIFT_WIDTH = 12;
   localparam int IDX_WIDTH   = 48;

   // Register file layout
   localparam int DATA_WIDTH  = 32;
   localparam int NUM_REGS    = 2 * MAX_DIMS;
   localparam int REG_BITS    = $clog2(NUM_REGS);
   localparam int ADDR_WIDTH  = REG_BITS + 2;
   localparam int REG_EXTENT_BASE = 0;
   localparam int REG_SHIFT_BASE  = MAX_DIMS;

   // Modulo unit: one remainder bit per cycle
   localparam int MOD_STEPS    = EXT_WIDTH;
   localparam int MOD_CNT_BITS = $clog2(MOD_STEPS + 1);

   localparam logic [EXT_WIDTH-1:0] EXT_MAX = EXT_WIDTH'(1) << EXTENT_BITS;
   localparam logic [EXT_WIDTH-1:0] EXT_MIN = EXT_WIDTH'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIM,
      ST_MOD,
      ST_EMIT
   } state_type;

   typedef enum logic {
      SEL_COORD,
      SEL_SHIFT
   } mod_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        start;
      logic        mac;
      logic        mod_start;
      mod_sel_type mod_sel;
      logic        emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic c_ok;
      logic s_ok;
      logic last_dim;
      logic mod_done;
      logic mod_busy;
      logic out_free;
   } status_type;

   // Zero counts as one, anything above the maximum saturates
   function automatic logic [EXT_WIDTH-1:0] eff_extent(input logic [EXT_WIDTH-1:0] raw);
      logic [EXT_WIDTH-1:0] e;
      if (raw == '0) begin
         e = EXT_MIN;
      end else if (raw > EXT_MAX) begin
         e = EXT_MAX;
      end else begin
         e = raw;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/trl_req_if.sv
// Channel interfaces for the request and response transactions.
`default_nettype none

interface trl_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface trl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [trl_pkg::IDX_WIDTH-1:0] dest_index;
   logic [trl_pkg::IDX_WIDTH-1:0] source_index;
   logic                         last;

   modport source (output valid, output dest_index, output source_index, output last,
                   input ready);
   modport sink   (input valid, input dest_index, input source_index, input last,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/trl_csr.sv
// APB-style register file holding the per-dimension extents and shifts.
`default_nettype none

module trl_csr (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              psel,
   input  wire logic                                              penable,
   input  wire logic                                              pwrite,
   input  wire logic [trl_pkg::ADDR_WIDTH-1:0]                    paddr,
   input  wire logic [trl_pkg::DATA_WIDTH-1:0]                    pwdata,
   output logic      [trl_pkg::DATA_WIDTH-1:0]                    prdata,
   output logic                                                   pready,
   output logic      [trl_pkg::MAX_DIMS-1:0][trl_pkg::EXT_WIDTH-1:0]   extent,
   output logic      [trl_pkg::MAX_DIMS-1:0][trl_pkg::SHIFT_WIDTH-1:0] shift
);
   import trl_pkg::*;

   logic [MAX_DIMS-1:0][EXT_WIDTH-1:0]   extent_ff;
   logic [MAX_DIMS-1:0][SHIFT_WIDTH-1:0] shift_ff;
   logic [REG_BITS-1:0]                  reg_idx;
   logic                                 wr_en;
   logic [DIM_BITS-1:0]                  ext_sel;
   logic [DIM_BITS-1:0]                  shf_sel;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_WIDTH-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign ext_sel = DIM_BITS'(reg_idx - REG_BITS'(REG_EXTENT_BASE));
   assign shf_sel = DIM_BITS'(reg_idx - REG_BITS'(REG_SHIFT_BASE));

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            extent_ff[d] <= EXT_MIN;
            shift_ff[d]  <= '0;
         end
      end else if (wr_en) begin
         if (reg_idx < REG_BITS'(REG_SHIFT_BASE)) begin
            extent_ff[ext_sel] <= pwdata[EXT_WIDTH-1:0];
         end else begin
            shift_ff[shf_sel] <= pwdata[SHIFT_WIDTH-1:0];
         end
      end
   end

   // Read mux
   always_comb begin
      if (reg_idx < REG_BITS'(REG_SHIFT_BASE)) begin
         prdata = DATA_WIDTH'(extent_ff[ext_sel]);
      end else begin
         prdata = DATA_WIDTH'(shift_ff[shf_sel]);
      end
   end

   assign extent = extent_ff;
   assign shift  = shift_ff;

endmodule

`default_nettype wire

// File: hw/rtl/trl_mod.sv
// Bit-serial remainder unit: operand modulo divisor, one bit per cycle.
`default_nettype none

module trl_mod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [trl_pkg::EXT_WIDTH-1:0] operand,
   input  wire logic [trl_pkg::EXT_WIDTH-1:0] divisor,
   output logic                               busy,
   output logic                               done,
   output logic      [trl_pkg::EXT_WIDTH-1:0] result
);
   import trl_pkg::*;

   logic                    busy_ff, busy_in;
   logic [MOD_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [EXT_WIDTH-1:0]    rem_ff, rem_in;
   logic [EXT_WIDTH-1:0]    opd_ff, opd_in;
   logic [EXT_WIDTH-1:0]    div_ff, div_in;
   logic [EXT_WIDTH-1:0]    shifted;
   logic [EXT_WIDTH-1:0]    rem_step;

   // Remainder stays below the divisor, so its top bit is free for the shift
   assign shifted  = {rem_ff[EXT_WIDTH-2:0], opd_ff[EXT_WIDTH-1]};
   assign rem_step = (shifted >= div_ff) ? (shifted - div_ff) : shifted;

   assign busy   = busy_ff;
   assign done   = busy_ff && (cnt_ff == MOD_CNT_BITS'(1));
   assign result = rem_step;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      opd_in  = opd_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CNT_BITS'(MOD_STEPS);
         rem_in  = '0;
         opd_in  = operand;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = rem_step;
         opd_in = {opd_ff[EXT_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - MOD_CNT_BITS'(1);
         if (cnt_ff == MOD_CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      opd_ff <= opd_in;
      div_ff <= div_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/trl_dp.sv
// Datapath: coordinate counters, source index accumulation and result register.
`default_nettype none

module trl_dp (
   input  wire logic                                                  clock,
   input  wire logic                                                  reset,
   input  wire trl_pkg::cmd_type                                      cmd,
   output trl_pkg::status_type                                        status,
   input  wire logic                                                  restart,
   input  wire logic [trl_pkg::MAX_DIMS-1:0][trl_pkg::EXT_WIDTH-1:0]   extent,
   input  wire logic [trl_pkg::MAX_DIMS-1:0][trl_pkg::SHIFT_WIDTH-1:0] shift,
   output logic                                                       rsp_valid,
   input  wire logic                                                  rsp_ready,
   output logic      [trl_pkg::IDX_WIDTH-1:0]                         rsp_dest_index,
   output logic      [trl_pkg::IDX_WIDTH-1:0]                         rsp_source_index,
   output logic                                                       rsp_last
);
   import trl_pkg::*;

   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] coord_ff, coord_in, coord_adv;
   logic [IDX_WIDTH-1:0]                 dest_ff, dest_in;
   logic [IDX_WIDTH-1:0]                 acc_ff, acc_in;
   logic [DIM_BITS-1:0]                  dim_ff, dim_in;
   logic [EXT_WIDTH-1:0]                 c_red_ff, c_red_in;
   logic [EXT_WIDTH-1:0]                 s_red_ff, s_red_in;
   logic                                 c_vld_ff, c_vld_in;
   logic                                 s_vld_ff, s_vld_in;
   mod_sel_type                          sel_ff, sel_in;
   logic                                 out_vld_ff, out_vld_in;
   logic [IDX_WIDTH-1:0]                 out_dest_ff, out_src_ff;
   logic                                 out_last_ff;

   logic [EXT_WIDTH-1:0] e_cur, c_cur, s_cur, sc, mod_opd, mod_res;
   logic [IDX_WIDTH-1:0] mac_val;
   logic                 mod_busy, mod_done;
   logic                 last_all;
   logic                 carry;
   logic                 out_free;

   // Current dimension operands, with reduced values taking over once computed
   assign e_cur = eff_extent(extent[dim_ff]);
   assign c_cur = c_vld_ff ? c_red_ff : EXT_WIDTH'(coord_ff[dim_ff]);
   assign s_cur = s_vld_ff ? s_red_ff : EXT_WIDTH'(shift[dim_ff]);

   // Source coordinate (c - s) mod e, both already below e
   assign sc      = (c_cur >= s_cur) ? (c_cur - s_cur) : (c_cur + e_cur - s_cur);
   assign mac_val = IDX_WIDTH'(acc_ff * IDX_WIDTH'(e_cur)) + IDX_WIDTH'(sc);
   assign mod_opd = (cmd.mod_sel == SEL_COORD) ? c_cur : s_cur;

   trl_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mod_start),
      .operand (mod_opd),
      .divisor (e_cur),
      .busy    (mod_busy),
      .done    (mod_done),
      .result  (mod_res)
   );

   // Last element and counter advance, innermost dimension first
   always_comb begin
      last_all  = 1'b1;
      carry     = 1'b1;
      coord_adv = coord_ff;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if ((EXT_WIDTH'(coord_ff[d]) + EXT_WIDTH'(1)) < eff_extent(extent[d])) begin
            last_all = 1'b0;
         end
      end
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         if (carry) begin
            if ((EXT_WIDTH'(coord_ff[d]) + EXT_WIDTH'(1)) < eff_extent(extent[d])) begin
               coord_adv[d] = coord_ff[d] + EXTENT_BITS'(1);
               carry        = 1'b0;
            end else begin
               coord_adv[d] = '0;
            end
         end
      end
   end

   assign out_free = !out_vld_ff || rsp_ready;

   // Next-state logic for the datapath registers
   always_comb begin
      coord_in   = coord_ff;
      dest_in    = dest_ff;
      acc_in     = acc_ff;
      dim_in     = dim_ff;
      c_red_in   = c_red_ff;
      s_red_in   = s_red_ff;
      c_vld_in   = c_vld_ff;
      s_vld_in   = s_vld_ff;
      sel_in     = sel_ff;
      out_vld_in = out_vld_ff && !rsp_ready;

      if (cmd.start) begin
         acc_in   = '0;
         dim_in   = '0;
         c_vld_in = 1'b0;
         s_vld_in = 1'b0;
         if (restart) begin
            coord_in = '0;
            dest_in  = '0;
         end
      end

      if (cmd.mac) begin
         acc_in   = mac_val;
         dim_in   = dim_ff + DIM_BITS'(1);
         c_vld_in = 1'b0;
         s_vld_in = 1'b0;
      end

      if (cmd.mod_start) begin
         sel_in = cmd.mod_sel;
      end

      if (mod_done) begin
         if (sel_ff == SEL_COORD) begin
            c_red_in = mod_res;
            c_vld_in = 1'b1;
         end else begin
            s_red_in = mod_res;
            s_vld_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         out_vld_in = 1'b1;
         if (last_all) begin
            coord_in = '0;
            dest_in  = '0;
         end else begin
            coord_in = coord_adv;
            dest_in  = dest_ff + IDX_WIDTH'(1);
         end
      end
   end

   // Control and counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff   <= '0;
         dest_ff    <= '0;
         dim_ff     <= '0;
         c_vld_ff   <= 1'b0;
         s_vld_ff   <= 1'b0;
         sel_ff     <= SEL_COORD;
         out_vld_ff <= 1'b0;
      end else begin
         coord_ff   <= coord_in;
         dest_ff    <= dest_in;
         dim_ff     <= dim_in;
         c_vld_ff   <= c_vld_in;
         s_vld_ff   <= s_vld_in;
         sel_ff     <= sel_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      c_red_ff <= c_red_in;
      s_red_ff <= s_red_in;
      if (cmd.emit) begin
         out_dest_ff <= dest_ff;
         out_src_ff  <= acc_ff;
         out_last_ff <= last_all;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_dest_index   = out_dest_ff;
   assign rsp_source_index = out_src_ff;
   assign rsp_last         = out_last_ff;

   always_comb begin
      status.c_ok     = c_cur < e_cur;
      status.s_ok     = s_cur < e_cur;
      status.last_dim = dim_ff == DIM_BITS'(MAX_DIMS - 1);
      status.mod_done = mod_done;
      status.mod_busy = mod_busy;
      status.out_free = out_free;
   end

endmodule

`default_nettype wire

// File: hw/rtl/trl_ctrl.sv
// Controller: sequences acceptance, per-dimension steps, reductions and result load.
`default_nettype none

module trl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire trl_pkg::status_type status,
   output trl_pkg::cmd_type         cmd
);
   import trl_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIM;
            end
         end
         ST_DIM: begin
            if (status.c_ok && status.s_ok) begin
               if (status.last_dim) begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (status.mod_done) begin
               state_in = ST_DIM;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.start     = 1'b0;
      cmd.mac       = 1'b0;
      cmd.mod_start = 1'b0;
      cmd.mod_sel   = SEL_COORD;
      cmd.emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_DIM: begin
            if (status.c_ok && status.s_ok) begin
               cmd.mac = 1'b1;
            end else begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel   = status.c_ok ? SEL_SHIFT : SEL_COORD;
            end
         end
         ST_MOD: begin
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tensor_roll_address_generator_top.sv
// Top level of the tensor roll address generator.
//
// Produces one (destination, source) linear index pair per request transaction
// for a circular roll of a row-major tensor of up to four dimensions.
// Request channel carries restart: 1 starts a new pass at destination zero.
// Response channel carries dest_index, source_index and last (final element;
// the next transaction then starts over at zero on its own).
// Extents and shifts are written through the APB-style port; the user must write
// them only while idle, as the block itself does not enforce it. A request is
// taken, then one step per dimension accumulates the source index (a 48x13
// multiply-add per step), then the output register is loaded once it is free
// and the response is driven from it. A coordinate or shift that is not below
// its extent is first reduced by a bit-serial remainder unit.
// Reset clears the coordinate counters and the destination counter, sets all
// extents to 1 and all shifts to 0. A stalled receiver holds the response in
// the output register; the next request is still taken and processed, and its
// result waits until the output register is free.
`default_nettype none

module tensor_roll_address_generator_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   trl_req_if.sink                            req_if,
   trl_rsp_if.source                          rsp_if,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [trl_pkg::ADDR_WIDTH-1:0] paddr,
   input  wire logic [trl_pkg::DATA_WIDTH-1:0] pwdata,
   output logic      [trl_pkg::DATA_WIDTH-1:0] prdata,
   output logic                               pready
);
   import trl_pkg::*;

   logic [MAX_DIMS-1:0][EXT_WIDTH-1:0]   extent;
   logic [MAX_DIMS-1:0][SHIFT_WIDTH-1:0] shift;
   cmd_type                              cmd;
   status_type                           status;
   logic                                 req_ready;
   logic                                 rsp_valid;
   logic [IDX_WIDTH-1:0]                 rsp_dest_index;
   logic [IDX_WIDTH-1:0]                 rsp_source_index;
   logic                                 rsp_last;

   trl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .extent  (extent),
      .shift   (shift)
   );

   trl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   trl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .restart          (req_if.restart),
      .extent           (extent),
      .shift            (shift),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_source_index (rsp_source_index),
      .rsp_last         (rsp_last)
   );

   assign req_if.ready        = req_ready;
   assign rsp_if.valid        = rsp_valid;
   assign rsp_if.dest_index   = rsp_dest_index;
   assign rsp_if.source_index = rsp_source_index;
   assign rsp_if.last         = rsp_last;

   // Remainder unit is never restarted mid-operation
   assert property (@(posedge clock) disable iff (reset)
      cmd.mod_start |-> !status.mod_busy)
      else $error("remainder unit restarted while busy");

   // A result load never overwrites a response that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_if.valid || rsp_if.ready))
      else $error("output register overwritten");

   // A response appears only after a result load
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.emit))
      else $error("response valid without result load");

   // One transaction in flight: no acceptance in the cycle after one
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted back to back");

endmodule

`default_nettype wire
